// ----- hw/rtl/whmtf_pkg.sv -----
package whmtf_pkg;

    localparam int MAX_WINDOWS_DEF = 16;
    localparam int COORD_BITS_DEF  = 16;
    localparam int LABEL_W         = 16;
    localparam int CMD_W           = 2;
    localparam int IN_COORD_W      = 16;

    // input command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // result kinds
    localparam logic RK_CLICK = 1'b0;
    localparam logic RK_ENTRY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // input transaction taken
        logic load_we;     // append window
        logic clear_d;     // depth pointer to top
        logic inc_d;       // next depth
        logic fetch;       // read window RAMs at slot of current depth
        logic out_hit;     // load click answer, hit
        logic out_miss;    // load click answer, miss
        logic out_entry;   // load stacking order entry
        logic move_front;  // move slot at current depth to the top
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cmd_load;
        logic cmd_click;
        logic cmd_read;
        logic empty;
        logic full;
        logic hit;
        logic d_last;
        logic mode_read;
    } dp_status_t;

endpackage

// ----- hw/rtl/window_hit_move_to_front_top.sv -----
// Window stack with hit test and move-to-front. Up to MAX_WINDOWS labeled
// rectangles are kept in a stacking order, top first. A load transaction
// (command 0) appends a window at the bottom and gives no
// result; loads past capacity and command 3 are dropped. A click (command 1)
// scans from the top for the first rectangle holding the point (all edges
// inclusive, coordinates cut to COORD_BITS), moves that window to the top and
// returns one result with hit and label; a miss returns hit 0, label 0. A
// read (command 2) returns one result per window, top to bottom, with last
// on the bottom entry; nothing when empty. One transaction is handled at a
// time: s_ready is high only while idle. A click passes from the accepting
// idle state through a fetch and a check state per window examined to the
// output state (straight there when empty); a read passes through fetch,
// check and output once per entry, waiting in output while m_ready is low.
// This follows from the registered reads of the rectangle and label RAMs,
// one window per fetch-and-compare pair, and the one-entry output register.
module window_hit_move_to_front_top #(
    parameter int MAX_WINDOWS = whmtf_pkg::MAX_WINDOWS_DEF,
    parameter int COORD_BITS  = whmtf_pkg::COORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input transactions
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [whmtf_pkg::CMD_W-1:0]      s_command,
    input  logic [whmtf_pkg::LABEL_W-1:0]    s_window_label,
    input  logic [whmtf_pkg::IN_COORD_W-1:0] s_left_x,
    input  logic [whmtf_pkg::IN_COORD_W-1:0] s_right_x,
    input  logic [whmtf_pkg::IN_COORD_W-1:0] s_bottom_y,
    input  logic [whmtf_pkg::IN_COORD_W-1:0] s_top_y,
    input  logic [whmtf_pkg::IN_COORD_W-1:0] s_point_x,
    input  logic [whmtf_pkg::IN_COORD_W-1:0] s_point_y,
    // result transactions
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_result_kind,
    output logic                             m_hit,
    output logic [whmtf_pkg::LABEL_W-1:0]    m_label_out,
    output logic                             m_last
);

    whmtf_pkg::dp_cmd_t    cmd;
    whmtf_pkg::dp_status_t status;

    // sequencer: idle / fetch / check / output
    whmtf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // window RAMs, stacking order registers, compare and result register
    whmtf_dp #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_command      (s_command),
        .s_window_label (s_window_label),
        .s_left_x       (s_left_x),
        .s_right_x      (s_right_x),
        .s_bottom_y     (s_bottom_y),
        .s_top_y        (s_top_y),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .m_result_kind  (m_result_kind),
        .m_hit          (m_hit),
        .m_label_out    (m_label_out),
        .m_last         (m_last)
    );

`ifndef SYNTHESIS
    // never take a new transaction while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while result pending");

    // click answers are single-result runs
    a_click_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == whmtf_pkg::RK_CLICK)) |-> m_last)
        else $error("click answer without last");

    // stacking order entries never carry a hit flag
    a_entry_nohit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> (m_result_kind == whmtf_pkg::RK_CLICK))
        else $error("hit flag on order entry");

    // a hit search moves the window to the top and shows its hit result in the next cycle
    a_move_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.move_front |=> (m_valid && m_hit))
        else $error("move-to-front without hit result");
`endif

endmodule

// ----- hw/rtl/whmtf_ram.sv -----
module whmtf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/whmtf_ctrl.sv -----
module whmtf_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  whmtf_pkg::dp_status_t  status,
    output whmtf_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept  = 1'b1;
                    cmd.clear_d = 1'b1;
                    if (status.cmd_load && !status.full) begin
                        cmd.load_we = 1'b1;
                    end
                    if (status.cmd_click) begin
                        if (status.empty) begin
                            cmd.out_miss = 1'b1;
                            state_next   = ST_OUT;
                        end else begin
                            state_next = ST_FETCH;
                        end
                    end
                    if (status.cmd_read && !status.empty) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.mode_read) begin
                    cmd.out_entry = 1'b1;
                    state_next    = ST_OUT;
                end else if (status.hit) begin
                    cmd.out_hit    = 1'b1;
                    cmd.move_front = 1'b1;
                    state_next     = ST_OUT;
                end else if (status.d_last) begin
                    cmd.out_miss = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    cmd.inc_d  = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (status.mode_read && !status.d_last) begin
                        cmd.inc_d  = 1'b1;
                        state_next = ST_FETCH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/whmtf_dp.sv -----
module whmtf_dp #(
    parameter int MAX_WINDOWS = whmtf_pkg::MAX_WINDOWS_DEF,
    parameter int COORD_BITS  = whmtf_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  whmtf_pkg::dp_cmd_t                  cmd,
    output whmtf_pkg::dp_status_t               status,
    input  logic [whmtf_pkg::CMD_W-1:0]         s_command,
    input  logic [whmtf_pkg::LABEL_W-1:0]       s_window_label,
    input  logic [whmtf_pkg::IN_COORD_W-1:0]    s_left_x,
    input  logic [whmtf_pkg::IN_COORD_W-1:0]    s_right_x,
    input  logic [whmtf_pkg::IN_COORD_W-1:0]    s_bottom_y,
    input  logic [whmtf_pkg::IN_COORD_W-1:0]    s_top_y,
    input  logic [whmtf_pkg::IN_COORD_W-1:0]    s_point_x,
    input  logic [whmtf_pkg::IN_COORD_W-1:0]    s_point_y,
    output logic                                m_result_kind,
    output logic                                m_hit,
    output logic [whmtf_pkg::LABEL_W-1:0]       m_label_out,
    output logic                                m_last
);

    localparam int SLOT_W  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int COUNT_W = $clog2(MAX_WINDOWS + 1);
    localparam int RECT_W  = 4 * COORD_BITS;

    // keep low COORD_BITS of a 16-bit port, zero-extend when wider
    function automatic logic [COORD_BITS-1:0] to_coord(
        input logic [whmtf_pkg::IN_COORD_W-1:0] v
    );
        logic [31:0] w;
        w = {16'd0, v};
        return w[COORD_BITS-1:0];
    endfunction

    logic [COUNT_W-1:0]            count_reg, count_next;
    logic [SLOT_W-1:0]             d_reg, d_next;
    logic                          mode_read_reg;
    logic [COORD_BITS-1:0]         px_reg, py_reg;
    logic [SLOT_W-1:0]             order_reg [MAX_WINDOWS];
    logic [SLOT_W-1:0]             order_next [MAX_WINDOWS];
    logic                          kind_reg, hit_reg, last_reg;
    logic [whmtf_pkg::LABEL_W-1:0] label_reg;

    logic [SLOT_W-1:0]             wslot;
    logic [SLOT_W-1:0]             rslot;
    logic [RECT_W-1:0]             rect_wdata, rect_rdata;
    logic [whmtf_pkg::LABEL_W-1:0] label_rdata;
    logic [COORD_BITS-1:0]         r_left, r_right, r_bottom, r_top;
    logic                          hit;
    logic                          d_last;

    assign wslot = count_reg[SLOT_W-1:0];
    assign rslot = order_reg[d_reg];

    assign rect_wdata = {to_coord(s_top_y), to_coord(s_bottom_y),
                         to_coord(s_right_x), to_coord(s_left_x)};

    whmtf_ram #(.WIDTH(RECT_W), .DEPTH(MAX_WINDOWS)) u_rect_ram (
        .aclk  (aclk),
        .we    (cmd.load_we),
        .waddr (wslot),
        .wdata (rect_wdata),
        .re    (cmd.fetch),
        .raddr (rslot),
        .rdata (rect_rdata)
    );

    whmtf_ram #(.WIDTH(whmtf_pkg::LABEL_W), .DEPTH(MAX_WINDOWS)) u_label_ram (
        .aclk  (aclk),
        .we    (cmd.load_we),
        .waddr (wslot),
        .wdata (s_window_label),
        .re    (cmd.fetch),
        .raddr (rslot),
        .rdata (label_rdata)
    );

    assign r_left   = rect_rdata[COORD_BITS-1:0];
    assign r_right  = rect_rdata[2*COORD_BITS-1:COORD_BITS];
    assign r_bottom = rect_rdata[3*COORD_BITS-1:2*COORD_BITS];
    assign r_top    = rect_rdata[4*COORD_BITS-1:3*COORD_BITS];

    assign hit = (px_reg >= r_left) && (px_reg <= r_right) &&
                 (py_reg >= r_bottom) && (py_reg <= r_top);

    assign d_last = ((COUNT_W'(d_reg) + COUNT_W'(1)) == count_reg);

    always_comb begin
        count_next = count_reg;
        if (cmd.load_we) begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_comb begin
        d_next = d_reg;
        if (cmd.clear_d) begin
            d_next = '0;
        end else if (cmd.inc_d) begin
            d_next = d_reg + SLOT_W'(1);
        end
    end

    // stacking order: append on load, shift-down-and-insert on hit
    always_comb begin
        for (int i = 0; i < MAX_WINDOWS; i++) begin
            order_next[i] = order_reg[i];
        end
        if (cmd.load_we) begin
            order_next[wslot] = wslot;
        end
        if (cmd.move_front) begin
            for (int i = 1; i < MAX_WINDOWS; i++) begin
                if (SLOT_W'(i) <= d_reg) begin
                    order_next[i] = order_reg[i-1];
                end
            end
            order_next[0] = rslot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            d_reg         <= '0;
            mode_read_reg <= 1'b0;
            for (int i = 0; i < MAX_WINDOWS; i++) begin
                order_reg[i] <= SLOT_W'(i);
            end
        end else begin
            count_reg <= count_next;
            d_reg     <= d_next;
            for (int i = 0; i < MAX_WINDOWS; i++) begin
                order_reg[i] <= order_next[i];
            end
            if (cmd.accept) begin
                mode_read_reg <= (s_command == whmtf_pkg::CMD_READ);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg <= to_coord(s_point_x);
            py_reg <= to_coord(s_point_y);
        end
        if (cmd.out_hit) begin
            kind_reg  <= whmtf_pkg::RK_CLICK;
            hit_reg   <= 1'b1;
            label_reg <= label_rdata;
            last_reg  <= 1'b1;
        end else if (cmd.out_miss) begin
            kind_reg  <= whmtf_pkg::RK_CLICK;
            hit_reg   <= 1'b0;
            label_reg <= '0;
            last_reg  <= 1'b1;
        end else if (cmd.out_entry) begin
            kind_reg  <= whmtf_pkg::RK_ENTRY;
            hit_reg   <= 1'b0;
            label_reg <= label_rdata;
            last_reg  <= d_last;
        end
    end

    assign status.cmd_load  = (s_command == whmtf_pkg::CMD_LOAD);
    assign status.cmd_click = (s_command == whmtf_pkg::CMD_CLICK);
    assign status.cmd_read  = (s_command == whmtf_pkg::CMD_READ);
    assign status.empty     = (count_reg == '0);
    assign status.full      = (count_reg == COUNT_W'(MAX_WINDOWS));
    assign status.hit       = hit;
    assign status.d_last    = d_last;
    assign status.mode_read = mode_read_reg;

    assign m_result_kind = kind_reg;
    assign m_hit         = hit_reg;
    assign m_label_out   = label_reg;
    assign m_last        = last_reg;

endmodule
